/* hdl/mlt_pkg.sv */
// Package for the mutex lock table: table sizes, command and status codes,
// and the controller command word. No dependencies.
`default_nettype none
package mlt_pkg;

  localparam int NumEntries = 16;
  localparam int WaitSlots  = 8;
  localparam int PidW       = 8;

  localparam int EntryIdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int SlotIdxW  = (WaitSlots > 1) ? $clog2(WaitSlots) : 1;
  localparam int SlotAddrW = (NumEntries * WaitSlots > 1) ? $clog2(NumEntries * WaitSlots) : 1;

  // Port widths fixed by the interface.
  localparam int CmdW    = 2;
  localparam int IndexW  = 4;
  localparam int ReqPidW = 8;
  localparam int StatusW = 4;
  localparam int WokenW  = 8;

  localparam logic [CmdW-1:0] CmdLock  = 2'd0;
  localparam logic [CmdW-1:0] CmdFree  = 2'd1;
  localparam logic [CmdW-1:0] CmdAlloc = 2'd2;
  localparam logic [CmdW-1:0] CmdClean = 2'd3;

  localparam logic [StatusW-1:0] StGranted   = 4'd0;
  localparam logic [StatusW-1:0] StQueued    = 4'd1;
  localparam logic [StatusW-1:0] StWaitFull  = 4'd2;
  localparam logic [StatusW-1:0] StInvalid   = 4'd3;
  localparam logic [StatusW-1:0] StReleased  = 4'd4;
  localparam logic [StatusW-1:0] StHanded    = 4'd5;
  localparam logic [StatusW-1:0] StAllocated = 4'd6;
  localparam logic [StatusW-1:0] StNoSpace   = 4'd7;
  localparam logic [StatusW-1:0] StCleaned   = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // execute the accepted word this cycle
  } ctrl_cmd_t;

endpackage
`default_nettype wire

/* hdl/mlt_ram.sv */
// Generic single-port RAM with registered read data.
// Standalone; used for the waiter pid store.
`default_nettype none
module mlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 128,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/mlt_ctrl.sv */
// Controller for the mutex lock table: idle / respond sequencer and handshakes.
// Depends on mlt_pkg.
`default_nettype none
module mlt_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output mlt_pkg::ctrl_cmd_t cmd_o
);
  import mlt_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StResp = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StResp;
      end
      StResp: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = (state_q == StResp);
  assign cmd_o.exec     = in_valid_i && (state_q == StIdle);

endmodule
`default_nettype wire

/* hdl/mlt_dpath.sv */
// Datapath for the mutex lock table: entry flags, slot occupancy, search logic,
// result registers and the pid RAM. Depends on mlt_pkg and mlt_ram.
`default_nettype none
module mlt_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mlt_pkg::ctrl_cmd_t          cmd_i,
  input  wire logic [mlt_pkg::CmdW-1:0]    cmd_code_i,
  input  wire logic [mlt_pkg::IndexW-1:0]  mutex_index_i,
  input  wire logic [mlt_pkg::ReqPidW-1:0] requester_pid_i,
  output logic      [mlt_pkg::StatusW-1:0] status_o,
  output logic      [mlt_pkg::WokenW-1:0]  woken_pid_o,
  output logic      [mlt_pkg::IndexW-1:0]  result_index_o
);
  import mlt_pkg::*;

  logic [NumEntries-1:0]                used_q, used_d;
  logic [NumEntries-1:0]                held_q, held_d;
  logic [NumEntries-1:0][WaitSlots-1:0] occ_q, occ_d;

  logic [StatusW-1:0] status_q, status_d;
  logic [IndexW-1:0]  res_idx_q, res_idx_d;
  logic               handed_q, handed_d;

  logic [EntryIdxW-1:0] ent;
  logic                 in_range, entry_ok;
  logic [WaitSlots-1:0] occ_row;
  logic                 free_found, busy_found, unused_found;
  logic [SlotIdxW-1:0]  free_slot, busy_slot;
  logic [EntryIdxW-1:0] unused_ent;

  logic                 ram_we, ram_re;
  logic [SlotAddrW-1:0] ram_addr;
  logic [PidW-1:0]      ram_rdata;

  assign ent      = EntryIdxW'(mutex_index_i);
  assign in_range = (int'(mutex_index_i) < NumEntries);
  assign entry_ok = in_range && used_q[ent];
  assign occ_row  = occ_q[ent];

  // Lowest empty and lowest occupied slot of the addressed entry.
  always_comb begin
    free_found = 1'b0;
    busy_found = 1'b0;
    free_slot  = '0;
    busy_slot  = '0;
    for (int s = WaitSlots - 1; s >= 0; s--) begin
      if (!occ_row[s]) begin
        free_found = 1'b1;
        free_slot  = SlotIdxW'(s);
      end
      if (occ_row[s]) begin
        busy_found = 1'b1;
        busy_slot  = SlotIdxW'(s);
      end
    end
  end

  // Lowest unused entry, for allocate.
  always_comb begin
    unused_found = 1'b0;
    unused_ent   = '0;
    for (int e = NumEntries - 1; e >= 0; e--) begin
      if (!used_q[e]) begin
        unused_found = 1'b1;
        unused_ent   = EntryIdxW'(e);
      end
    end
  end

  always_comb begin
    used_d    = used_q;
    held_d    = held_q;
    occ_d     = occ_q;
    status_d  = status_q;
    res_idx_d = res_idx_q;
    handed_d  = handed_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = SlotAddrW'(ent) * SlotAddrW'(WaitSlots) + SlotAddrW'(free_slot);
    if (cmd_i.exec) begin
      status_d  = StInvalid;
      res_idx_d = mutex_index_i;
      handed_d  = 1'b0;
      case (cmd_code_i)
        CmdLock: begin
          if (entry_ok) begin
            if (!held_q[ent]) begin
              held_d[ent] = 1'b1;
              status_d    = StGranted;
            end else if (free_found) begin
              occ_d[ent][free_slot] = 1'b1;
              ram_we   = 1'b1;
              status_d = StQueued;
            end else begin
              status_d = StWaitFull;
            end
          end
        end
        CmdFree: begin
          if (entry_ok) begin
            if (busy_found) begin
              occ_d[ent][busy_slot] = 1'b0;
              ram_re   = 1'b1;
              ram_addr = SlotAddrW'(ent) * SlotAddrW'(WaitSlots) + SlotAddrW'(busy_slot);
              handed_d = 1'b1;
              status_d = StHanded;
            end else begin
              held_d[ent] = 1'b0;
              status_d    = StReleased;
            end
          end
        end
        CmdAlloc: begin
          if (unused_found) begin
            used_d[unused_ent] = 1'b1;
            status_d  = StAllocated;
            res_idx_d = IndexW'(unused_ent);
          end else begin
            status_d  = StNoSpace;
            res_idx_d = '0;
          end
        end
        CmdClean: begin
          if (in_range) begin
            used_d[ent] = 1'b0;
            held_d[ent] = 1'b0;
            occ_d[ent]  = '0;
            status_d    = StCleaned;
          end
        end
        default: status_d = StInvalid;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= NumEntries'(1);
      held_q <= '0;
      occ_q  <= '0;
    end else begin
      used_q <= used_d;
      held_q <= held_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    res_idx_q <= res_idx_d;
    handed_q  <= handed_d;
  end

  mlt_ram #(
    .Width (PidW),
    .Depth (NumEntries * WaitSlots),
    .AddrW (SlotAddrW)
  ) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (PidW'(requester_pid_i)),
    .rdata_o (ram_rdata)
  );

  assign status_o       = status_q;
  assign result_index_o = res_idx_q;
  // The pid RAM holds its read word until the next free that hands over a
  // lock, so it stays put while the receiver stalls.
  assign woken_pid_o    = handed_q ? WokenW'(ram_rdata) : '0;

endmodule
`default_nettype wire

/* hdl/mutex_lock_table.sv */
// Top level of the mutex lock table: controller, datapath and assertions.
// Depends on mlt_pkg, mlt_ctrl, mlt_dpath and mlt_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command word: cmd_i,
//   mutex_index_i and requester_pid_i. Output channel (out_valid_o /
//   out_ready_i) returns exactly one result word per command: status_o,
//   woken_pid_o and result_index_o.
//   The result word is valid in the cycle after the command is taken.
//   A new command is taken only after the previous result has been taken;
//   the sequencer alternates between taking a word and presenting its result,
//   and the waiter pid store is a RAM with a registered read port, so the
//   woken pid of a free is available in the cycle after the slot search.
//   Stall: while out_valid_o waits for out_ready_i, the result word holds and
//   no new command is taken.
//   Reset (rst_ni low, asynchronous): entry 0 is marked used, all other
//   entries unused, all locks and waiter slots clear. The pid RAM is not
//   cleared; a pid is only read from a slot that was written.
`default_nettype none
module mutex_lock_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mlt_pkg::CmdW-1:0]    cmd_i,
  input  wire logic [mlt_pkg::IndexW-1:0]  mutex_index_i,
  input  wire logic [mlt_pkg::ReqPidW-1:0] requester_pid_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [mlt_pkg::StatusW-1:0] status_o,
  output logic      [mlt_pkg::WokenW-1:0]  woken_pid_o,
  output logic      [mlt_pkg::IndexW-1:0]  result_index_o
);
  import mlt_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  // Sequence the handshakes: take a word, then present its result.
  mlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (ctrl_cmd)
  );

  // Execute the command against the table in the cycle it is taken.
  mlt_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .cmd_code_i      (cmd_i),
    .mutex_index_i   (mutex_index_i),
    .requester_pid_i (requester_pid_i),
    .status_o        (status_o),
    .woken_pid_o     (woken_pid_o),
    .result_index_o  (result_index_o)
  );

  // Never take a word while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");

  // A taken word yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("no result after accepted word");

  // Only a hand-over reports a pid.
  a_woken_only_handed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StHanded)) |-> (woken_pid_o == '0))
    else $error("woken pid without hand-over");

  // Allocate with no space reports entry 0.
  a_no_space_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StNoSpace)) |-> (result_index_o == '0))
    else $error("no-space result with nonzero index");

endmodule
`default_nettype wire
